/* hdl/i2cmbs_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Item types, opcodes and the phase tables shared by the sequencer modules.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

    localparam logic [3:0] OP_TICK  = 4'd0;
    localparam logic [3:0] OP_START = 4'd1;
    localparam logic [3:0] OP_STOP  = 4'd2;
    localparam logic [3:0] OP_WRITE = 4'd3;
    localparam logic [3:0] OP_READ  = 4'd4;
    localparam logic [3:0] OP_WACK  = 4'd5;
    localparam logic [3:0] OP_ACK   = 4'd6;
    localparam logic [3:0] OP_NACK  = 4'd7;
    localparam logic [3:0] OP_CHECK = 4'd8;

    localparam logic [7:0] PHASE_TICKS_RST = 8'd8;
    localparam logic [4:0] WRITE_LAST_STEP = 5'd23;

    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] data_byte;
        logic       sda_in;
        logic       scl_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_result;
        logic       rejected;
    } t_out_item;

    typedef struct packed {
        logic [3:0] kind;
        logic [4:0] step;
    } t_phase;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] tx;
    } t_line;

    typedef struct packed {
        logic tick;
        logic clear;
    } t_tmr_ctrl;

    function automatic logic [5:0] seq_length(input logic [3:0] cmd);
        logic [5:0] len;
        case (cmd) inside
            OP_START:                 len = 6'd3;
            OP_STOP:                  len = 6'd2;
            OP_WRITE:                 len = 6'd24;
            OP_READ:                  len = 6'd16;
            OP_WACK, OP_ACK, OP_NACK: len = 6'd3;
            OP_CHECK:                 len = 6'd32;
            default:                  len = 6'd0;
        endcase
        return len;
    endfunction

    function automatic t_phase resolve(input logic [3:0] cmd, input logic [4:0] idx);
        t_phase p;
        p.kind = cmd;
        p.step = idx;
        if (cmd == OP_CHECK) begin
            if (idx < 5'd3) begin
                p.kind = OP_START;
                p.step = idx;
            end else if (idx < 5'd27) begin
                p.kind = OP_WRITE;
                p.step = idx - 5'd3;
            end else if (idx < 5'd30) begin
                p.kind = OP_WACK;
                p.step = idx - 5'd27;
            end else begin
                p.kind = OP_STOP;
                p.step = idx - 5'd30;
            end
        end
        return p;
    endfunction

    function automatic logic [1:0] step_mod3(input logic [4:0] step);
        logic [1:0] r;
        case (step) inside
            5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27, 5'd30:
                r = 2'd0;
            5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28, 5'd31:
                r = 2'd1;
            default:
                r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic t_line enter_phase(input t_phase p, input t_line cur);
        t_line nxt;
        nxt = cur;
        case (p.kind) inside
            OP_START: begin
                if (p.step == 5'd0) begin
                    nxt.sda = 1'b1;
                    nxt.scl = 1'b1;
                end else if (p.step == 5'd1) begin
                    nxt.sda = 1'b0;
                end else begin
                    nxt.scl = 1'b0;
                end
            end
            OP_STOP: begin
                if (p.step == 5'd0) begin
                    nxt.sda = 1'b0;
                    nxt.scl = 1'b1;
                end else begin
                    nxt.sda = 1'b1;
                end
            end
            OP_WRITE: begin
                case (step_mod3(p.step))
                    2'd0: nxt.sda = cur.tx[7];
                    2'd1: nxt.scl = 1'b1;
                    default: begin
                        nxt.scl = 1'b0;
                        if (p.step == WRITE_LAST_STEP) begin
                            nxt.sda = 1'b1;
                        end
                        nxt.tx = {cur.tx[6:0], 1'b0};
                    end
                endcase
            end
            OP_READ: begin
                nxt.scl = ~p.step[0];
            end
            OP_WACK, OP_ACK, OP_NACK: begin
                if (p.step == 5'd0) begin
                    nxt.sda = (p.kind != OP_ACK);
                end else if (p.step == 5'd1) begin
                    nxt.scl = 1'b1;
                end else begin
                    nxt.scl = 1'b0;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
        return nxt;
    endfunction

endpackage

/* hdl/i2cmbs_timer.sv */
// ----------------------------------------------------------------------------
// Phase timer
// Counts tick items within a bus phase and flags the tick that ends it.
// ----------------------------------------------------------------------------
module i2cmbs_timer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  i2cmbs_pkg::t_tmr_ctrl i_ctrl,
    input  logic [7:0]            i_phase_ticks,
    output logic                  o_phase_end
);
    import i2cmbs_pkg::*;

    logic [7:0] r_tick_count;
    logic [7:0] n_tick_count;
    logic [7:0] w_limit;
    logic [7:0] w_inc;

    assign w_limit     = (i_phase_ticks == 8'd0) ? 8'd1 : i_phase_ticks;
    assign w_inc       = r_tick_count + 8'd1;
    assign o_phase_end = i_ctrl.tick && (w_inc >= w_limit);

    always_comb begin
        n_tick_count = r_tick_count;
        if (i_ctrl.clear) begin
            n_tick_count = 8'd0;
        end else if (i_ctrl.tick) begin
            n_tick_count = o_phase_end ? 8'd0 : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= 8'd0;
        end else begin
            r_tick_count <= n_tick_count;
        end
    end

endmodule

/* hdl/i2cmbs_core.sv */
// ----------------------------------------------------------------------------
// Sequencer core
// Holds the command and line state and works out the result of one item.
// ----------------------------------------------------------------------------
module i2cmbs_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  i2cmbs_pkg::t_in_item  i_item,
    input  logic [7:0]            i_phase_ticks,
    output i2cmbs_pkg::t_out_item o_res
);
    import i2cmbs_pkg::*;

    logic [3:0] r_cmd;
    logic [4:0] r_idx;
    logic [7:0] r_rx;
    logic       r_ack;
    t_line      r_line;

    logic [3:0] n_cmd;
    logic [4:0] n_idx;
    logic [7:0] n_rx;
    logic       n_ack;
    t_line      n_line;

    logic       w_busy;
    logic       w_done;
    logic       w_rej;
    logic       w_phase_end;
    logic [5:0] w_idx_inc;
    t_phase     w_cur;
    t_phase     w_nxt;
    t_phase     w_first;
    t_tmr_ctrl  w_tmr;
    logic       w_is_cmd;
    logic       w_bus_free;

    assign w_busy     = (r_cmd != OP_TICK);
    assign w_is_cmd   = (i_item.opcode != OP_TICK) && (i_item.opcode <= OP_CHECK);
    assign w_bus_free = i_item.sda_in && i_item.scl_in;
    assign w_idx_inc  = {1'b0, r_idx} + 6'd1;
    assign w_cur      = resolve(r_cmd, r_idx);
    assign w_nxt      = resolve(r_cmd, w_idx_inc[4:0]);
    assign w_first    = resolve(i_item.opcode, 5'd0);

    assign w_tmr.tick  = i_en && (i_item.opcode == OP_TICK) && w_busy;
    assign w_tmr.clear = i_en && w_is_cmd && !w_busy &&
                         !((i_item.opcode == OP_CHECK) && !w_bus_free);

    i2cmbs_timer u_timer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_tmr),
        .i_phase_ticks (i_phase_ticks),
        .o_phase_end   (w_phase_end)
    );

    always_comb begin
        n_cmd  = r_cmd;
        n_idx  = r_idx;
        n_rx   = r_rx;
        n_ack  = r_ack;
        n_line = r_line;
        w_done = 1'b0;
        w_rej  = 1'b0;
        if (w_phase_end) begin
            if ((w_cur.kind == OP_READ) && !w_cur.step[0]) begin
                n_rx = {r_rx[6:0], i_item.sda_in};
            end else if ((w_cur.kind == OP_WACK) && (w_cur.step == 5'd1)) begin
                n_ack = i_item.sda_in;
            end else if ((w_cur.kind == OP_ACK) && (w_cur.step == 5'd2)) begin
                n_line.sda = 1'b1;
            end
            if (w_idx_inc >= seq_length(r_cmd)) begin
                n_cmd  = OP_TICK;
                n_idx  = 5'd0;
                w_done = 1'b1;
            end else begin
                n_idx  = w_idx_inc[4:0];
                n_line = enter_phase(w_nxt, n_line);
            end
        end else if (i_en && w_is_cmd) begin
            if (w_busy) begin
                w_rej = 1'b1;
            end else if ((i_item.opcode == OP_CHECK) && !w_bus_free) begin
                n_ack  = 1'b1;
                w_done = 1'b1;
            end else begin
                n_cmd = i_item.opcode;
                n_idx = 5'd0;
                if ((i_item.opcode == OP_WRITE) || (i_item.opcode == OP_CHECK)) begin
                    n_line.tx = i_item.data_byte;
                end
                if (i_item.opcode == OP_READ) begin
                    n_rx = 8'd0;
                end
                n_line = enter_phase(w_first, n_line);
            end
        end
    end

    always_comb begin
        o_res.scl_out    = n_line.scl;
        o_res.sda_out    = n_line.sda;
        o_res.busy_res   = (n_cmd != OP_TICK);
        o_res.done_res   = w_done;
        o_res.read_data  = n_rx;
        o_res.ack_result = n_ack;
        o_res.rejected   = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= OP_TICK;
            r_idx      <= 5'd0;
            r_rx       <= 8'd0;
            r_ack      <= 1'b1;
            r_line.scl <= 1'b1;
            r_line.sda <= 1'b1;
            r_line.tx  <= 8'd0;
        end else if (i_en) begin
            r_cmd  <= n_cmd;
            r_idx  <= n_idx;
            r_rx   <= n_rx;
            r_ack  <= n_ack;
            r_line <= n_line;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> ({1'b0, r_idx} < seq_length(r_cmd)))
        else $error("phase index past sequence length");

    a_idle_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_busy |-> (r_idx == 5'd0))
        else $error("phase index nonzero while idle");

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_done) |=> !w_busy)
        else $error("sequence still active after done");

endmodule

/* hdl/i2c_master_bit_sequencer.sv */
// An accepted item is held in the input register; its result is registered
// into the result register when that register is free or being taken.
// Throughput: one item per cycle; the input register and the result register
// advance together whenever the result slot is free or being taken.
// Reset (synchronous, active low): idle, SCL and SDA released, ack 1,
// phase_ticks 8; the block is ready for items as soon as reset is released.
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Drives open-drain SCL and SDA one bus phase at a time from command and
// tick items, with a configurable phase length.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cmbs_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cmbs_pkg::t_out_item o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [7:0]            i_cfg_data
);
    import i2cmbs_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic [7:0] r_phase_ticks;
    logic       w_adv;
    t_out_item  w_res;

    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    i2cmbs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_item        (r_in),
        .i_phase_ticks (r_phase_ticks),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (i_cfg_valid) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    a_done_not_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.done_res && o_out_data.rejected))
        else $error("item both done and rejected");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.done_res) |-> !o_out_data.busy_res)
        else $error("done reported while still busy");

    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.rejected) |-> o_out_data.busy_res)
        else $error("rejected while idle");

    a_fill_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_valid)
        else $error("processed item did not reach the result register");

endmodule
